// ----- hw/rtl/blind_motor_position_controller_top_defines.svh -----
// Assertion macros shared by the blind motor position controller RTL.
// Defining ASSERT_OFF compiles every assertion away.
`ifndef BLIND_MOTOR_POSITION_CONTROLLER_TOP_DEFINES_SVH
`define BLIND_MOTOR_POSITION_CONTROLLER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define BMPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bmpc assertion failed");

`define BMPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmpc implication failed");

`define BMPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmpc next-cycle check failed");

`else

`define BMPC_ASSERT(lbl, clk, rst_n, prop)
`define BMPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BMPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/bmpc_pkg.sv -----
// Types and constants of the blind motor position controller.
// No dependencies; imported by the top level.
`default_nettype none

package bmpc_pkg;

    localparam int SENSOR_TIMEOUT_MS = 3000;
    localparam int CHANGE_STEP       = 3;
    localparam int ARRIVE_BAND       = 10;

    localparam logic [9:0]  SLIDER_CLOSED_MAX = 10'd50;
    localparam logic [9:0]  SLIDER_OPEN_MIN   = 10'd950;
    localparam logic [15:0] STALL_RESET_MS    = 16'd5000;
    localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

    typedef enum logic [2:0] {
        FUNC_TICK   = 3'd0,
        FUNC_STOP   = 3'd1,
        FUNC_SLIDER = 3'd2,
        FUNC_OPEN   = 3'd3,
        FUNC_CLOSE  = 3'd4,
        FUNC_CLEAR  = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_OPENING = 2'd1,
        MODE_CLOSING = 2'd2,
        MODE_FAULT   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        POS_CLOSED  = 2'd0,
        POS_HALF    = 2'd1,
        POS_OPEN    = 2'd2,
        POS_UNKNOWN = 2'd3
    } pos_t;

    typedef enum logic [1:0] {
        DRIVE_OFF   = 2'd0,
        DRIVE_OPEN  = 2'd1,
        DRIVE_CLOSE = 2'd2
    } drive_t;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_TIMEOUT = 2'd1,
        CAUSE_STALL   = 2'd2
    } cause_t;

    typedef enum logic [2:0] {
        REG_CLOSED_ANGLE = 3'd0,
        REG_OPEN_ANGLE   = 3'd1,
        REG_REVERSE      = 3'd2,
        REG_CALIBRATED   = 3'd3,
        REG_STALL_MS     = 3'd4
    } reg_index_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bmpc_if.sv -----
// Valid/ready channel interfaces for commands and results of the controller.
// Depends on nothing but the field widths fixed here.
`default_nettype none

interface bmpc_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        func;
    logic [9:0]        slider;
    logic signed [15:0] angle;
    logic              angle_valid;

    modport source (output valid, output func, output slider, output angle,
                    output angle_valid, input ready);
    modport sink   (input valid, input func, input slider, input angle,
                    input angle_valid, output ready);
endinterface

interface bmpc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] motor_drive;
    logic [1:0] run_mode;
    logic [1:0] position_code;
    logic [1:0] fault_cause;
    logic       arrived;
    logic       ignored;

    modport source (output valid, output motor_drive, output run_mode,
                    output position_code, output fault_cause, output arrived,
                    output ignored, input ready);
    modport sink   (input valid, input motor_drive, input run_mode,
                    input position_code, input fault_cause, input arrived,
                    input ignored, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/blind_motor_position_controller_top.sv -----
// Top level of the blind motor position controller: input register,
// decision logic and result register. Uses bmpc_pkg, bmpc_if.sv and the defines header.
//
// Usage: commands and one-millisecond ticks arrive as beats on the cmd channel;
// every accepted beat yields exactly one beat on the res channel, in order.
// Calibration and direction registers are written through wr_en, wr_index and
// wr_data; the user must write them only while the block is idle, which the block
// itself does not enforce. Indexes beyond the register list are dropped.
// Each command beat passes the input register, then the result register, to res.
// Throughput: one beat per cycle unless res.ready is low, set by the single pass
// of compare and add logic between the input register and the result register,
// which also updates the motor state.
// Reset: the mode goes idle, the held position becomes unknown, target, counters
// and last moved angle clear, and the stall timeout returns to 5000 ms.
// Stall: while res.ready is low, the result register holds its beat and the input
// register can still take one more command beat; after that cmd.ready drops until
// the receiver takes the waiting result.
`default_nettype none
`include "blind_motor_position_controller_top_defines.svh"

module blind_motor_position_controller_top
    import bmpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [15:0] wr_data,
    bmpc_cmd_if.sink         cmd,
    bmpc_res_if.source       res
);

    logic signed [15:0] closed_angle_reg;
    logic signed [15:0] open_angle_reg;
    logic               reverse_reg;
    logic               calibrated_reg;
    logic [15:0]        stall_ms_reg;

    logic               s1_valid_reg;
    logic [2:0]         s1_func_reg;
    logic [9:0]         s1_slider_reg;
    logic signed [15:0] s1_angle_reg;
    logic               s1_angle_valid_reg;

    mode_t              mode_reg, mode_next;
    pos_t               pos_reg, pos_next;
    logic signed [15:0] target_reg, target_next;
    logic signed [15:0] moved_angle_reg, moved_angle_next;
    logic [15:0]        ms_start_reg, ms_start_next;
    logic [15:0]        ms_change_reg, ms_change_next;

    logic               res_valid_reg;
    logic [1:0]         drive_reg, drive_next;
    logic [1:0]         cause_reg;
    logic               arrived_reg;
    logic               ignored_reg;

    cause_t             cause_next;
    logic               arrived_next;
    logic               ignored_next;

    logic               out_free;
    logic               s1_fire;

    logic               start_move;
    pos_t               goal;
    logic signed [16:0] angle_sum;
    logic signed [15:0] half_angle;
    logic signed [15:0] goal_angle;
    logic               go_up;
    logic [15:0]        start_inc;
    logic [15:0]        change_inc;

    function automatic logic [16:0] absdiff(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
        logic signed [16:0] d;
        d = {a[15], a} - {b[15], b};
        return d[16] ? 17'(-d) : 17'(d);
    endfunction

    assign out_free  = !res_valid_reg || res.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign cmd.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_angle_reg <= '0;
            open_angle_reg   <= '0;
            reverse_reg      <= 1'b0;
            calibrated_reg   <= 1'b0;
            stall_ms_reg     <= STALL_RESET_MS;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CLOSED_ANGLE: closed_angle_reg <= wr_data;
                REG_OPEN_ANGLE:   open_angle_reg   <= wr_data;
                REG_REVERSE:      reverse_reg      <= wr_data[0];
                REG_CALIBRATED:   calibrated_reg   <= wr_data[0];
                REG_STALL_MS:     stall_ms_reg     <= wr_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_func_reg        <= cmd.func;
            s1_slider_reg      <= cmd.slider;
            s1_angle_reg       <= cmd.angle;
            s1_angle_valid_reg <= cmd.angle_valid;
        end
    end

    assign start_inc  = (ms_start_reg == COUNT_MAX) ? COUNT_MAX : ms_start_reg + 16'd1;
    assign change_inc = (ms_change_reg == COUNT_MAX) ? COUNT_MAX : ms_change_reg + 16'd1;
    assign angle_sum  = {closed_angle_reg[15], closed_angle_reg}
                      + {open_angle_reg[15], open_angle_reg};
    assign half_angle = angle_sum[16:1];

    always_comb
    begin
        mode_next        = mode_reg;
        pos_next         = pos_reg;
        target_next      = target_reg;
        moved_angle_next = moved_angle_reg;
        ms_start_next    = ms_start_reg;
        ms_change_next   = ms_change_reg;
        cause_next       = CAUSE_NONE;
        arrived_next     = 1'b0;
        ignored_next     = 1'b0;
        start_move       = 1'b0;
        goal             = POS_CLOSED;
        goal_angle       = closed_angle_reg;
        go_up            = 1'b0;

        case (s1_func_reg) inside
            FUNC_TICK:
            begin
                if (mode_reg == MODE_OPENING || mode_reg == MODE_CLOSING)
                begin
                    ms_start_next  = start_inc;
                    ms_change_next = change_inc;
                    if (!s1_angle_valid_reg)
                    begin
                        if (start_inc > 16'(SENSOR_TIMEOUT_MS))
                        begin
                            mode_next  = MODE_FAULT;
                            cause_next = CAUSE_TIMEOUT;
                        end
                    end
                    else
                    begin
                        if (absdiff(s1_angle_reg, moved_angle_reg) > 17'(CHANGE_STEP))
                        begin
                            moved_angle_next = s1_angle_reg;
                            ms_change_next   = '0;
                        end
                        if (ms_change_next > stall_ms_reg)
                        begin
                            mode_next  = MODE_FAULT;
                            cause_next = CAUSE_STALL;
                        end
                        else if (absdiff(s1_angle_reg, target_reg) < 17'(ARRIVE_BAND))
                        begin
                            mode_next    = MODE_IDLE;
                            arrived_next = 1'b1;
                            if (absdiff(target_reg, closed_angle_reg) < 17'(ARRIVE_BAND))
                                pos_next = POS_CLOSED;
                            else if (absdiff(target_reg, open_angle_reg) < 17'(ARRIVE_BAND))
                                pos_next = POS_OPEN;
                            else
                                pos_next = POS_HALF;
                        end
                    end
                end
            end
            FUNC_CLEAR:
            begin
                mode_next = MODE_IDLE;
            end
            FUNC_STOP, FUNC_SLIDER, FUNC_OPEN, FUNC_CLOSE:
            begin
                if (mode_reg == MODE_FAULT)
                    ignored_next = 1'b1;
                else if (s1_func_reg == FUNC_STOP)
                    mode_next = MODE_IDLE;
                else if (!calibrated_reg)
                    ignored_next = 1'b1;
                else
                    start_move = 1'b1;

                if (s1_func_reg == FUNC_SLIDER)
                begin
                    if (s1_slider_reg <= SLIDER_CLOSED_MAX)
                        goal = POS_CLOSED;
                    else if (s1_slider_reg >= SLIDER_OPEN_MIN)
                        goal = POS_OPEN;
                    else
                        goal = POS_HALF;
                end
                else if (s1_func_reg == FUNC_OPEN)
                    goal = (pos_reg == POS_CLOSED) ? POS_HALF : POS_OPEN;
                else
                    goal = (pos_reg == POS_OPEN) ? POS_HALF : POS_CLOSED;
            end
            default:
            begin
            end
        endcase

        case (goal)
            POS_CLOSED: goal_angle = closed_angle_reg;
            POS_OPEN:   goal_angle = open_angle_reg;
            default:    goal_angle = half_angle;
        endcase
        go_up = (goal_angle > s1_angle_reg) ^ reverse_reg;

        if (start_move)
        begin
            target_next      = goal_angle;
            ms_start_next    = '0;
            ms_change_next   = '0;
            moved_angle_next = s1_angle_reg;
            mode_next        = go_up ? MODE_OPENING : MODE_CLOSING;
        end

        case (mode_next)
            MODE_OPENING: drive_next = DRIVE_OPEN;
            MODE_CLOSING: drive_next = DRIVE_CLOSE;
            default:      drive_next = DRIVE_OFF;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            pos_reg         <= POS_UNKNOWN;
            target_reg      <= '0;
            moved_angle_reg <= '0;
            ms_start_reg    <= '0;
            ms_change_reg   <= '0;
        end
        else if (s1_fire)
        begin
            mode_reg        <= mode_next;
            pos_reg         <= pos_next;
            target_reg      <= target_next;
            moved_angle_reg <= moved_angle_next;
            ms_start_reg    <= ms_start_next;
            ms_change_reg   <= ms_change_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            drive_reg   <= drive_next;
            cause_reg   <= cause_next;
            arrived_reg <= arrived_next;
            ignored_reg <= ignored_next;
        end
    end

    logic [1:0] res_mode_reg;
    logic [1:0] res_pos_reg;

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_mode_reg <= mode_next;
            res_pos_reg  <= pos_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.motor_drive   = drive_reg;
    assign res.run_mode      = res_mode_reg;
    assign res.position_code = res_pos_reg;
    assign res.fault_cause   = cause_reg;
    assign res.arrived       = arrived_reg;
    assign res.ignored       = ignored_reg;

    // The change counter is cleared with the start counter and never runs ahead of it.
    `BMPC_ASSERT(a_counter_order, clk, rst_n, ms_change_reg <= ms_start_reg)
    `BMPC_ASSERT_IMPL(a_fault_mode, clk, rst_n, res.valid && res.fault_cause != CAUSE_NONE,
                      res.run_mode == MODE_FAULT)
    `BMPC_ASSERT_IMPL(a_arrive_idle, clk, rst_n, res.valid && res.arrived,
                      res.run_mode == MODE_IDLE && res.position_code != POS_UNKNOWN)
    `BMPC_ASSERT_IMPL(a_drive_follows, clk, rst_n, res.valid,
                      (res.motor_drive != DRIVE_OFF) ==
                      (res.run_mode == MODE_OPENING || res.run_mode == MODE_CLOSING))
    `BMPC_ASSERT_NEXT(a_fire_shows, clk, rst_n, s1_fire, res.valid)

endmodule

`default_nettype wire
